>>> src/mots_pkg.sv
// ----------------------------------------------------------------------------
// mots_pkg
// Shared types and constants of the one-shot timer scheduler: channel count,
// compare constants, item kinds, control state and the minimum-search token.
// ----------------------------------------------------------------------------
package mots_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int CNT_W        = 32;
   localparam int CMP_W        = 16;
   localparam int CHAN_W       = 3;
   localparam int MASK_W       = 8;
   localparam int WALK_W       = $clog2(NUM_CHANNELS + 1);

   localparam logic [CMP_W-1:0] CMP_RESET = 16'd18432;
   localparam logic [CMP_W-1:0] CMP_LIMIT = 16'hFFFF;

   // item kinds carried on tuser
   localparam logic [1:0] FUNC_SET     = 2'd0;
   localparam logic [1:0] FUNC_STOP    = 2'd1;
   localparam logic [1:0] FUNC_MATCH   = 2'd2;
   localparam logic [1:0] FUNC_COLLECT = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_EMIT
   } state_type;

   // running minimum handed from cell to cell
   typedef struct packed {
      logic             active;
      logic [CMP_W-1:0] best;
   } token_type;

   // broadcast command to every cell
   typedef struct packed {
      logic             load;
      logic             update;
      logic             clear_done;
      logic [CNT_W-1:0] count;
      logic [CMP_W-1:0] elapsed;
   } cell_cmd_type;

endpackage

>>> src/mots_cell.sv
// ----------------------------------------------------------------------------
// mots_cell
// One channel of the scheduler: countdown, pending mark and completion flag,
// plus one stage of the systolic minimum search over the countdowns.
// ----------------------------------------------------------------------------
module mots_cell
   import mots_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  logic         sel,
   input  token_type    token_prev,
   output token_type    token_next,
   output logic         expire,
   output logic         done
);

   logic [CNT_W-1:0] remaining_ff, remaining_in;
   logic             pending_ff, pending_in;
   logic             done_ff, done_in;
   token_type        token_ff, token_in;
   logic [CNT_W-1:0] elapsed_ext;
   logic             counting;

   assign elapsed_ext = {{(CNT_W-CMP_W){1'b0}}, cmd.elapsed};
   assign counting    = (remaining_ff != '0) && !pending_ff;
   assign expire      = counting && (remaining_ff <= elapsed_ext);

   always_comb begin
      remaining_in = remaining_ff;
      pending_in   = pending_ff;
      done_in      = done_ff;
      if (cmd.load && sel) begin
         remaining_in = cmd.count;
         pending_in   = 1'b1;
      end
      if (cmd.update) begin
         if (expire) begin
            remaining_in = '0;
            done_in      = 1'b1;
         end else if (counting) begin
            remaining_in = remaining_ff - elapsed_ext;
         end
         pending_in = 1'b0;
      end
      if (cmd.clear_done) begin
         done_in = 1'b0;
      end
   end

   // keep the smaller of the incoming minimum and this countdown, if the countdown is nonzero and fits in CMP_W bits
   always_comb begin
      token_in = token_prev;
      if ((remaining_ff != '0) && (remaining_ff[CNT_W-1:CMP_W] == '0) &&
          (remaining_ff[CMP_W-1:0] < token_prev.best)) begin
         token_in.active = 1'b1;
         token_in.best   = remaining_ff[CMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         pending_ff   <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         remaining_ff <= remaining_in;
         pending_ff   <= pending_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      token_ff <= token_in;
   end

   assign token_next = token_ff;
   assign done       = done_ff;

endmodule

>>> src/multichannel_oneshot_timer_scheduler_core.sv
// ----------------------------------------------------------------------------
// multichannel_oneshot_timer_scheduler_core
// Per-channel one-shot countdowns sharing one 16-bit compare timer, kept in a
// row of channel cells with a minimum search passed along the row.
//
//   channel  direction  tuser        tdata (low bit up)
//   req_     in         func[1:0]    channel[2:0] cycle_count[34:3]
//                                    elapsed_ticks[50:35], zero pad to 56
//   rsp_     out        -            stop_mask[7:0] compare_value[23:8]
//                                    timer_active[24] complete_mask[32:25],
//                                    zero pad to 40
//
// A set or collect word goes from accept through EMIT into the output register;
// an update first waits in WALK while the minimum search walks the cell row one
// cell a cycle, then goes through EMIT. One word is in flight at a time; a new
// word is accepted as soon as the previous result sits in the output register.
// Synchronous active-high reset clears all countdowns, marks and flags and
// loads the compare value 18432. A stalled result holds the block in EMIT.
// ----------------------------------------------------------------------------
module multichannel_oneshot_timer_scheduler_core
   import mots_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // channel, cycle_count, elapsed_ticks, pad
   input  logic [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // stop_mask, compare_value, timer_active,
                                    // complete_mask, pad
);

   state_type             state_ff, state_in;
   logic [WALK_W-1:0]     walk_ff, walk_in;
   logic [CMP_W-1:0]      compare_ff, compare_in;
   logic [MASK_W-1:0]     hold_stop_ff, hold_stop_in;
   logic [MASK_W-1:0]     hold_complete_ff, hold_complete_in;
   logic                  hold_active_ff, hold_active_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [39:0]           rsp_data_ff, rsp_data_in;

   logic [CHAN_W-1:0]     req_channel;
   logic [CNT_W-1:0]      req_count;
   logic [CMP_W-1:0]      req_elapsed;
   logic                  accept;
   cell_cmd_type          cmd;
   logic [NUM_CHANNELS-1:0] sel_vec;
   logic [NUM_CHANNELS-1:0] expire_vec;
   logic [NUM_CHANNELS-1:0] done_vec;
   logic [NUM_CHANNELS+MASK_W-1:0] expire_pad;
   logic [NUM_CHANNELS+MASK_W-1:0] done_pad;
   token_type             token_w [NUM_CHANNELS+1];

   assign req_channel = req_tdata[2:0];
   assign req_count   = req_tdata[34:3];
   assign req_elapsed = req_tdata[50:35];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign expire_pad = {{MASK_W{1'b0}}, expire_vec};
   assign done_pad   = {{MASK_W{1'b0}}, done_vec};

   assign token_w[0].active = 1'b0;
   assign token_w[0].best   = CMP_LIMIT;

   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         sel_vec[i] = ({{(32-CHAN_W){1'b0}}, req_channel} == 32'(i));
      end
   end

   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
      mots_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .sel        (sel_vec[g]),
         .token_prev (token_w[g]),
         .token_next (token_w[g+1]),
         .expire     (expire_vec[g]),
         .done       (done_vec[g])
      );
   end

   always_comb begin
      state_in         = state_ff;
      walk_in          = walk_ff;
      compare_in       = compare_ff;
      hold_stop_in     = hold_stop_ff;
      hold_complete_in = hold_complete_ff;
      hold_active_in   = hold_active_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;

      cmd.load       = 1'b0;
      cmd.update     = 1'b0;
      cmd.clear_done = 1'b0;
      cmd.count      = req_count;
      cmd.elapsed    = (req_tuser == FUNC_MATCH) ? compare_ff : req_elapsed;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hold_stop_in     = '0;
               hold_complete_in = '0;
               hold_active_in   = 1'b0;
               walk_in          = '0;
               case (req_tuser)
                  FUNC_SET: begin
                     cmd.load = 1'b1;
                     state_in = ST_EMIT;
                  end
                  FUNC_COLLECT: begin
                     cmd.clear_done   = 1'b1;
                     hold_complete_in = done_pad[MASK_W-1:0];
                     state_in         = ST_EMIT;
                  end
                  FUNC_STOP, FUNC_MATCH: begin
                     cmd.update   = 1'b1;
                     hold_stop_in = expire_pad[MASK_W-1:0];
                     state_in     = ST_WALK;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // wait for the minimum to reach the end of the row
            if (walk_ff == WALK_W'(NUM_CHANNELS)) begin
               hold_active_in = token_w[NUM_CHANNELS].active;
               if (token_w[NUM_CHANNELS].active) begin
                  compare_in = token_w[NUM_CHANNELS].best;
               end
               state_in = ST_EMIT;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, hold_complete_ff, hold_active_ff,
                               compare_ff, hold_stop_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_ff      <= '0;
         compare_ff   <= CMP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         compare_ff   <= compare_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_stop_ff     <= hold_stop_in;
      hold_complete_ff <= hold_complete_in;
      hold_active_ff   <= hold_active_in;
      rsp_data_ff      <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
